// ===== sv/lr35_pkg.sv =====
// ----------------------------------------------------------------------------
// lr35_pkg
// Shared types and codes for the SM83-style instruction subset executor:
// command codes, register file slots and flag bit positions.
// ----------------------------------------------------------------------------
package lr35_pkg;

  // Decoded command codes
  typedef enum logic [4:0] {
    CMD_NONE     = 5'd0,
    CMD_LD_R_N   = 5'd1,
    CMD_LD_HL_N  = 5'd2,
    CMD_LD_R_R   = 5'd3,
    CMD_LD_R_HL  = 5'd4,
    CMD_LD_HL_R  = 5'd5,
    CMD_LD_PAIR  = 5'd6,
    CMD_LD_BC_A  = 5'd7,
    CMD_LD_DE_A  = 5'd8,
    CMD_JR_NZ    = 5'd9,
    CMD_LD_HLI_A = 5'd10,
    CMD_LD_HLD_A = 5'd11,
    CMD_AND_R    = 5'd12,
    CMD_AND_HL   = 5'd13,
    CMD_XOR_R    = 5'd14,
    CMD_XOR_HL   = 5'd15,
    CMD_LDH_C_A  = 5'd16,
    CMD_LDH_A_C  = 5'd17,
    CMD_BIT_R    = 5'd18,
    CMD_BIT_HL   = 5'd19
  } cmd_t;

  // Register file slots (slot 6 is a spare entry)
  localparam logic [2:0] REG_B = 3'd0;
  localparam logic [2:0] REG_C = 3'd1;
  localparam logic [2:0] REG_D = 3'd2;
  localparam logic [2:0] REG_E = 3'd3;
  localparam logic [2:0] REG_H = 3'd4;
  localparam logic [2:0] REG_L = 3'd5;
  localparam logic [2:0] REG_A = 3'd7;

  // Pair codes for 16-bit loads
  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [1:0] PAIR_SP = 2'd3;

  // Flag bit positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // High page base for LDH (FF00+C)
  localparam logic [7:0] HIGH_PAGE = 8'hFF;

endpackage

// ===== sv/lr35902_instruction_subset_exec_core.sv =====
// ----------------------------------------------------------------------------
// lr35902_instruction_subset_exec_core
// Executes one decoded SM83-style instruction per word against a register
// file, flags, SP, PC, a cycle counter and a byte-wide data memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | command, selects, immediate,
//          |           |                     | jump offset, bit number
//  out_    | output    | out_valid/out_stall | PC, cycles, A, flags, B..L, SP
//
// Sustained rate is one word per cycle unless the clearing pass or out_stall
// holds the flow. A word is registered in the read stage (synchronous data
// memory read) and then executes, where registers and memory are written;
// results from execute are forwarded into the read address and a same-address
// write is bypassed into the read data. After reset a clearing pass zeroes
// the data memory, one byte a cycle, up to address MEM_DEPTH-1 while in_stall is high.
// out_stall holds the execute stage, which then raises in_stall.
// ----------------------------------------------------------------------------
module lr35902_instruction_subset_exec_core #(
  parameter int MEM_DEPTH = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  // instruction channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_command,
  input  logic [2:0]         in_dest_select,
  input  logic [2:0]         in_source_select,
  input  logic [15:0]        in_immediate,
  input  logic signed [7:0]  in_jump_offset,
  input  logic [2:0]         in_bit_number,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_program_counter_out,
  output logic [31:0]        out_cycle_count_out,
  output logic [7:0]         out_reg_a_out,
  output logic [3:0]         out_flags_out,
  output logic [7:0]         out_reg_b_out,
  output logic [7:0]         out_reg_c_out,
  output logic [7:0]         out_reg_d_out,
  output logic [7:0]         out_reg_e_out,
  output logic [7:0]         out_reg_h_out,
  output logic [7:0]         out_reg_l_out,
  output logic [15:0]        out_stack_pointer_out
);
  import lr35_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);
  // ceil(2^32 / MEM_DEPTH), exact quotient for any 16-bit address
  localparam logic [24:0] ADDR_RECIP =
    25'(((64'd1 << 32) + 64'(MEM_DEPTH) - 64'd1) / 64'(MEM_DEPTH));

  // 16-bit address modulo MEM_DEPTH by reciprocal multiply, quotient fits in 8 bits for MEM_DEPTH >= 256
  function automatic logic [AW-1:0] wrap_addr(input logic [15:0] a);
    logic [39:0] prod;
    logic [7:0]  q;
    logic [23:0] qm;
    logic [15:0] r;
    prod = 40'(a) * 40'(ADDR_RECIP);
    q    = prod[39:32];
    qm   = 24'(q) * 24'(MEM_DEPTH);
    r    = a - qm[15:0];
    return r[AW-1:0];
  endfunction

  // Architectural state (also the visible result)
  logic [7:0]  rf_r [8];
  logic [7:0]  rf_nxt [8];
  logic [3:0]  flags_r, flags_nxt;
  logic [15:0] sp_r, sp_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [31:0] cyc_r, cyc_nxt;
  logic        out_valid_r;

  // Read stage registers
  logic        a_valid_r;
  logic [4:0]  cmd_r;
  logic [2:0]  dst_r;
  logic [2:0]  src_r;
  logic [15:0] imm_r;
  logic [7:0]  off_r;
  logic [2:0]  bitn_r;

  // Data memory and its ports
  logic [7:0]    mem [MEM_DEPTH];
  logic [7:0]    mem_rd_r;
  logic          byp_r;
  logic [7:0]    byp_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;

  // Clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  // Execute-stage write port and helpers
  logic          ex_we;
  logic [15:0]   ex_waddr;
  logic [7:0]    ex_wdata;
  logic [7:0]    ex_rd;
  logic [15:0]   hl;
  logic [15:0]   hl_fwd;
  logic [15:0]   raddr16;
  logic [1:0]    pc_inc;
  logic [1:0]    cyc_inc;
  logic [7:0]    acc;
  logic [7:0]    bit_src;
  logic          do_bit;

  logic exec_fire;
  logic in_fire;

  // Handshake
  assign exec_fire = a_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = clr_busy_r || (a_valid_r && !exec_fire);
  assign in_fire   = in_valid && !in_stall;

  // Execute stage: next architectural state
  assign hl    = {rf_r[REG_H], rf_r[REG_L]};
  assign ex_rd = byp_r ? byp_data_r : mem_rd_r;

  always_comb begin
    rf_nxt    = rf_r;
    flags_nxt = flags_r;
    sp_nxt    = sp_r;
    pc_nxt    = pc_r;
    cyc_nxt   = cyc_r;
    ex_we     = 1'b0;
    ex_waddr  = hl;
    ex_wdata  = rf_r[REG_A];
    pc_inc    = 2'd0;
    cyc_inc   = 2'd0;
    acc       = rf_r[REG_A];
    bit_src   = rf_r[src_r];
    do_bit    = 1'b0;
    if (exec_fire) begin
      case (cmd_r)
        CMD_LD_R_N: begin
          rf_nxt[dst_r] = imm_r[7:0];
          pc_inc = 2'd2; cyc_inc = 2'd2;
        end
        CMD_LD_HL_N: begin
          ex_we = 1'b1; ex_wdata = imm_r[7:0];
          pc_inc = 2'd2; cyc_inc = 2'd3;
        end
        CMD_LD_R_R: begin
          rf_nxt[dst_r] = rf_r[src_r];
          pc_inc = 2'd1; cyc_inc = 2'd1;
        end
        CMD_LD_R_HL: begin
          rf_nxt[dst_r] = ex_rd;
          pc_inc = 2'd1; cyc_inc = 2'd2;
        end
        CMD_LD_HL_R: begin
          ex_we = 1'b1; ex_wdata = rf_r[src_r];
          pc_inc = 2'd1; cyc_inc = 2'd2;
        end
        CMD_LD_PAIR: begin
          case (dst_r[1:0])
            PAIR_BC: begin rf_nxt[REG_B] = imm_r[15:8]; rf_nxt[REG_C] = imm_r[7:0]; end
            PAIR_DE: begin rf_nxt[REG_D] = imm_r[15:8]; rf_nxt[REG_E] = imm_r[7:0]; end
            PAIR_HL: begin rf_nxt[REG_H] = imm_r[15:8]; rf_nxt[REG_L] = imm_r[7:0]; end
            default: sp_nxt = imm_r;
          endcase
          pc_inc = 2'd3; cyc_inc = 2'd3;
        end
        CMD_LD_BC_A: begin
          ex_we = 1'b1; ex_waddr = {rf_r[REG_B], rf_r[REG_C]};
          pc_inc = 2'd1; cyc_inc = 2'd2;
        end
        CMD_LD_DE_A: begin
          ex_we = 1'b1; ex_waddr = {rf_r[REG_D], rf_r[REG_E]};
          pc_inc = 2'd1; cyc_inc = 2'd2;
        end
        CMD_JR_NZ: begin
          // taken branch adds the offset and raises cyc_inc by one
          pc_inc = 2'd2;
          cyc_inc = flags_r[FLAG_Z] ? 2'd2 : 2'd3;
        end
        CMD_LD_HLI_A: begin
          ex_we = 1'b1;
          {rf_nxt[REG_H], rf_nxt[REG_L]} = hl + 16'd1;
          pc_inc = 2'd1; cyc_inc = 2'd2;
        end
        CMD_LD_HLD_A: begin
          ex_we = 1'b1;
          {rf_nxt[REG_H], rf_nxt[REG_L]} = hl - 16'd1;
          pc_inc = 2'd1; cyc_inc = 2'd2;
        end
        CMD_AND_R: begin
          acc = rf_r[REG_A] & rf_r[src_r];
          rf_nxt[REG_A] = acc;
          flags_nxt = {acc == 8'd0, 1'b0, 1'b1, 1'b0};
          pc_inc = 2'd1; cyc_inc = 2'd1;
        end
        CMD_AND_HL: begin
          acc = rf_r[REG_A] & ex_rd;
          rf_nxt[REG_A] = acc;
          flags_nxt = {acc == 8'd0, 1'b0, 1'b1, 1'b0};
          pc_inc = 2'd1; cyc_inc = 2'd2;
        end
        CMD_XOR_R: begin
          acc = rf_r[REG_A] ^ rf_r[src_r];
          rf_nxt[REG_A] = acc;
          flags_nxt = {acc == 8'd0, 3'b000};
          pc_inc = 2'd1; cyc_inc = 2'd1;
        end
        CMD_XOR_HL: begin
          acc = rf_r[REG_A] ^ ex_rd;
          rf_nxt[REG_A] = acc;
          flags_nxt = {acc == 8'd0, 3'b000};
          pc_inc = 2'd1; cyc_inc = 2'd2;
        end
        CMD_LDH_C_A: begin
          ex_we = 1'b1; ex_waddr = {HIGH_PAGE, rf_r[REG_C]};
          pc_inc = 2'd1; cyc_inc = 2'd2;
        end
        CMD_LDH_A_C: begin
          rf_nxt[REG_A] = ex_rd;
          pc_inc = 2'd1; cyc_inc = 2'd2;
        end
        CMD_BIT_R: begin
          do_bit = 1'b1;
          pc_inc = 2'd2; cyc_inc = 2'd2;
        end
        CMD_BIT_HL: begin
          do_bit = 1'b1; bit_src = ex_rd;
          pc_inc = 2'd2; cyc_inc = 2'd3;
        end
        default: begin
          pc_inc = 2'd0; cyc_inc = 2'd0;
        end
      endcase
      // BIT: Z from the tested bit, N clear, H set, C kept
      if (do_bit) begin
        flags_nxt = {!bit_src[bitn_r], 1'b0, 1'b1, flags_r[FLAG_C]};
      end
      pc_nxt  = pc_r + 16'(pc_inc);
      if (cmd_r == CMD_JR_NZ && !flags_r[FLAG_Z]) begin
        pc_nxt = pc_r + 16'(pc_inc) + {{8{off_r[7]}}, off_r};
      end
      cyc_nxt = cyc_r + 32'(cyc_inc);
    end
  end

  // Read address for the incoming word, using forwarded register values
  assign hl_fwd  = {rf_nxt[REG_H], rf_nxt[REG_L]};
  assign raddr16 = (in_command == CMD_LDH_A_C) ? {HIGH_PAGE, rf_nxt[REG_C]} : hl_fwd;
  assign mem_raddr = wrap_addr(raddr16);

  // Write port: clearing pass or execute stage
  assign mem_we    = clr_busy_r || ex_we;
  assign mem_waddr = clr_busy_r ? clr_addr_r : wrap_addr(ex_waddr);
  assign mem_wdata = clr_busy_r ? 8'd0 : ex_wdata;

  // Data memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      mem_rd_r <= mem[mem_raddr];
    end
  end

  // Bypass for a same-cycle write to the address being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (in_fire) begin
      byp_r <= ex_we && (wrap_addr(ex_waddr) == mem_raddr);
    end else if (exec_fire) begin
      byp_r <= 1'b0;
    end
    if (in_fire) begin
      byp_data_r <= ex_wdata;
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(MEM_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (exec_fire) begin
      a_valid_r <= 1'b0;
    end
    if (in_fire) begin
      cmd_r  <= in_command;
      dst_r  <= in_dest_select;
      src_r  <= in_source_select;
      imm_r  <= in_immediate;
      off_r  <= in_jump_offset;
      bitn_r <= in_bit_number;
    end
  end

  // Architectural state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        rf_r[i] <= 8'd0;
      end
      flags_r     <= 4'd0;
      sp_r        <= 16'd0;
      pc_r        <= 16'd0;
      cyc_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      rf_r    <= rf_nxt;
      flags_r <= flags_nxt;
      sp_r    <= sp_nxt;
      pc_r    <= pc_nxt;
      cyc_r   <= cyc_nxt;
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word is the architectural state after the last executed word
  assign out_valid               = out_valid_r;
  assign out_program_counter_out = pc_r;
  assign out_cycle_count_out     = cyc_r;
  assign out_reg_a_out           = rf_r[REG_A];
  assign out_flags_out           = flags_r;
  assign out_reg_b_out           = rf_r[REG_B];
  assign out_reg_c_out           = rf_r[REG_C];
  assign out_reg_d_out           = rf_r[REG_D];
  assign out_reg_e_out           = rf_r[REG_E];
  assign out_reg_h_out           = rf_r[REG_H];
  assign out_reg_l_out           = rf_r[REG_L];
  assign out_stack_pointer_out   = sp_r;

  // Checks
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> in_stall)
    else $error("word accepted during clearing pass");

  a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && out_valid_r && out_stall) |=> a_valid_r)
    else $error("read-stage word dropped while result stalled");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid_r)
    else $error("executed word produced no result");

  a_bypass_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> a_valid_r)
    else $error("bypass armed without a word in the read stage");

endmodule
